// ===== hdl/imu_sample_time_alignment_defines.svh =====
// ----------------------------------------------------------------------------
// IMU sample time alignment: assertion macros
// Concurrent assertion wrappers on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef IMU_SAMPLE_TIME_ALIGNMENT_DEFINES_SVH
`define IMU_SAMPLE_TIME_ALIGNMENT_DEFINES_SVH
`ifndef SYNTHESIS
`define STA_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("assertion failed");
`define STA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define STA_ASSERT(label, prop)
`define STA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/imu_sta_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU sample time alignment package
// Payload types, sequencer states, divider interface and FIFO slot helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package imu_sta_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int SLOT_W     = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int TIME_W     = 48;
    localparam int CH_N       = 10;
    localparam int DIV_REM_W  = 49;
    localparam int DIV_LOW_W  = 34;
    localparam int DIV_STEP_W = 6;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BEFORE = 2'd1;
    localparam logic [1:0] STAT_GAP    = 2'd2;
    localparam logic [1:0] STAT_FEW    = 2'd3;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_SYNC = 1'b1;

    typedef struct packed {
        logic               action;
        logic [47:0]        sample_time;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic signed [31:0] acc_z;
        logic signed [31:0] gyro_x;
        logic signed [31:0] gyro_y;
        logic signed [31:0] gyro_z;
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic signed [31:0] quat_w;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic [47:0]        out_time;
        logic signed [31:0] out_acc_x;
        logic signed [31:0] out_acc_y;
        logic signed [31:0] out_acc_z;
        logic signed [31:0] out_gyro_x;
        logic signed [31:0] out_gyro_y;
        logic signed [31:0] out_gyro_z;
        logic signed [31:0] out_quat_x;
        logic signed [31:0] out_quat_y;
        logic signed [31:0] out_quat_z;
        logic signed [31:0] out_quat_w;
    } t_out_item;

    // channel 0..5 motion, 6..9 quaternion x,y,z,w
    typedef struct packed {
        logic [TIME_W-1:0]       stime;
        logic [CH_N-1:0][31:0]   ch;
    } t_sample;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_RD0, S_EVAL, S_WDIV, S_BLEND, S_SQR, S_SQRT, S_NDIV, S_FIN
    } t_state;

    typedef struct packed {
        logic                  start;
        logic [DIV_REM_W-1:0]  init_rem;
        logic [DIV_LOW_W-1:0]  low;
        logic [TIME_W-1:0]     divisor;
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_LOW_W-1:0] quot;
    } t_div_rsp;

    function automatic logic [SLOT_W-1:0] slot_add(logic [SLOT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W+1)'(a) + (CNT_W+1)'(b);
        if (s >= (CNT_W+1)'(FIFO_DEPTH)) begin
            s = s - (CNT_W+1)'(FIFO_DEPTH);
        end
        return s[SLOT_W-1:0];
    endfunction

endpackage

// ===== hdl/imu_sta_div.sv =====
// ----------------------------------------------------------------------------
// IMU sample time alignment: restoring divider
// One quotient bit per cycle; remainder seed and dividend low bits given.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module imu_sta_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  imu_sta_pkg::t_div_req i_req,
    output imu_sta_pkg::t_div_rsp o_rsp
);
    import imu_sta_pkg::*;

    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_LOW_W-1:0]  r_low;
    logic [TIME_W-1:0]     r_div;
    logic [DIV_LOW_W-1:0]  r_quo;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [DIV_REM_W:0]    trial;
    logic                  take;

    assign trial = {r_rem, r_low[DIV_LOW_W-1]};
    assign take  = trial >= (DIV_REM_W+1)'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.init_rem;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_low <= {r_low[DIV_LOW_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_LOW_W-2:0], take};
            r_rem <= take ? DIV_REM_W'(trial - (DIV_REM_W+1)'(r_div)) : trial[DIV_REM_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ===== hdl/imu_sample_time_alignment.sv =====
// ----------------------------------------------------------------------------
// IMU sample time alignment
// Timestamped IMU sample FIFO with interpolation at a query time.
// ----------------------------------------------------------------------------
// A push transfer (action 0) stores one sample in a 16-entry FIFO, dropping
// the oldest when full. A sync transfer (action 1) gives a query time; the
// block drops samples until the query sits between the two oldest, checks
// both against max_gap and returns one result: status, query time and all
// ten channels blended at that time, quaternion normalized. Channels are
// zero unless status is ok. A sync holds o_stall high while it drops
// samples, divides for the weight, blends on one shared 32x32 multiplier,
// sums the squared norm, takes the root and divides each quaternion
// component. Pushes are taken while a finished result still waits on i_stall.
`timescale 1ns / 1ps
`include "imu_sample_time_alignment_defines.svh"
module imu_sample_time_alignment (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [47:0]            i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  imu_sta_pkg::t_in_item  i_data,
    output logic                   o_valid,
    input  logic                   i_stall,
    output imu_sta_pkg::t_out_item o_data
);
    import imu_sta_pkg::*;

    localparam logic signed [31:0] ONE30  = 32'sd1073741824;
    localparam logic signed [63:0] HALF30 = 64'sd536870912;

    // sample store, registered read
    t_sample mem [FIFO_DEPTH];
    t_sample r_rdata;
    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_en;
    t_sample           wr_sample;

    t_state r_state, n_state;
    logic [47:0]       r_max_gap;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [47:0]       r_q, n_q;
    t_sample           r_s0, n_s0, r_s1, n_s1;
    logic signed [31:0] r_wb, n_wb, r_wf, n_wf;
    logic [3:0]        r_ch, n_ch;
    logic [1:0]        r_ph, n_ph;
    logic [1:0]        r_k, n_k;
    logic signed [63:0] r_acc, n_acc;
    logic signed [63:0] r_prod;
    logic signed [31:0] mul_a, mul_b;
    logic [CH_N-1:0][31:0] r_res, n_res;
    logic [62:0]       r_sum, n_sum;
    logic [63:0]       r_rem, n_rem, r_root, n_root, r_bit, n_bit;
    logic [1:0]        r_status, n_status;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_out, n_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               accept;
    logic [47:0]        t0, t1;
    logic [63:0]        blend_sum;
    logic [63:0]        sq_trial;
    logic [31:0]        wsum;
    logic signed [31:0] qv;
    logic [31:0]        qmag;
    logic [60:0]        dvd;
    logic [31:0]        qnorm;

    imu_sta_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    assign wr_sample.stime = i_data.sample_time;
    assign wr_sample.ch    = {i_data.quat_w, i_data.quat_z, i_data.quat_y, i_data.quat_x,
                              i_data.gyro_z, i_data.gyro_y, i_data.gyro_x,
                              i_data.acc_z, i_data.acc_y, i_data.acc_x};
    assign wr_en   = accept && (i_data.action == ACT_PUSH);
    assign wr_slot = (r_count == CNT_W'(FIFO_DEPTH)) ? r_head : slot_add(r_head, r_count);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_slot] <= wr_sample;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_gap <= 48'd200000;
            r_head    <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                r_max_gap <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_s0     <= n_s0;
        r_s1     <= n_s1;
        r_wb     <= n_wb;
        r_wf     <= n_wf;
        r_ch     <= n_ch;
        r_ph     <= n_ph;
        r_k      <= n_k;
        r_acc    <= n_acc;
        r_res    <= n_res;
        r_sum    <= n_sum;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_bit    <= n_bit;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign t0        = r_s0.stime;
    assign t1        = r_rdata.stime;
    assign blend_sum = 64'(r_acc + r_prod + HALF30);
    assign sq_trial  = r_root + r_bit;
    assign wsum      = ({1'b0, div_rsp.quot[30:0]} + 32'd1) >> 1;
    assign qv        = r_res[6 + r_k];
    assign qmag      = qv[31] ? 32'(-qv) : qv;
    assign dvd       = {qmag, 29'b0} + {30'b0, r_root[31:1]};

    always_comb begin
        if (qv[31]) begin
            qnorm = (div_rsp.quot > 34'h0_8000_0000) ? 32'h8000_0000
                                                     : 32'(-div_rsp.quot[31:0]);
        end else begin
            qnorm = (div_rsp.quot > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : div_rsp.quot[31:0];
        end
    end

    always_comb begin
        n_state  = r_state;
        n_head   = r_head;
        n_count  = r_count;
        n_q      = r_q;
        n_s0     = r_s0;
        n_s1     = r_s1;
        n_wb     = r_wb;
        n_wf     = r_wf;
        n_ch     = r_ch;
        n_ph     = r_ph;
        n_k      = r_k;
        n_acc    = r_acc;
        n_res    = r_res;
        n_sum    = r_sum;
        n_rem    = r_rem;
        n_root   = r_root;
        n_bit    = r_bit;
        n_status = r_status;
        n_out    = r_out;
        n_ovalid = r_ovalid && i_stall;
        rd_addr  = r_head;
        mul_a    = '0;
        mul_b    = '0;
        div_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_data.action == ACT_PUSH) begin
                        if (r_count == CNT_W'(FIFO_DEPTH)) begin
                            n_head = slot_add(r_head, CNT_W'(1));
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end else begin
                        n_q     = i_data.sample_time;
                        n_res   = '0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // read of the oldest slot issued here
                if (r_count < CNT_W'(2)) begin
                    n_status = STAT_FEW;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                rd_addr = slot_add(r_head, CNT_W'(1));
                n_s0    = r_rdata;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (t0 > r_q) begin
                    n_status = STAT_BEFORE;
                    n_state  = S_FIN;
                end else if (t1 < r_q) begin
                    n_head  = slot_add(r_head, CNT_W'(1));
                    n_count = r_count - 1'b1;
                    n_state = S_CHECK;
                end else if ((r_q - t0 > r_max_gap) || (t1 - r_q > r_max_gap)) begin
                    n_head   = slot_add(r_head, CNT_W'(1));
                    n_count  = r_count - 1'b1;
                    n_status = STAT_GAP;
                    n_state  = S_FIN;
                end else begin
                    n_s1 = r_rdata;
                    n_ch = '0;
                    n_ph = '0;
                    if (t1 == t0) begin
                        n_wb    = '0;
                        n_wf    = ONE30;
                        n_state = S_BLEND;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.init_rem = {1'b0, r_q - t0};
                        div_req.low      = '0;
                        div_req.divisor  = t1 - t0;
                        div_req.steps    = DIV_STEP_W'(31);
                        n_state          = S_WDIV;
                    end
                end
            end
            S_WDIV: begin
                if (div_rsp.done) begin
                    n_wb    = wsum;
                    n_wf    = ONE30 - signed'(wsum);
                    n_state = S_BLEND;
                end
            end
            S_BLEND: begin
                // per channel, in turn: front product, back product, round
                unique case (r_ph)
                    2'd0: begin
                        mul_a = r_s0.ch[r_ch];
                        mul_b = r_wf;
                        n_ph  = 2'd1;
                    end
                    2'd1: begin
                        mul_a = r_s1.ch[r_ch];
                        mul_b = r_wb;
                        n_acc = r_prod;
                        n_ph  = 2'd2;
                    end
                    default: begin
                        n_res[r_ch] = blend_sum[61:30];
                        n_ph        = 2'd0;
                        if (r_ch == 4'(CH_N - 1)) begin
                            n_k     = '0;
                            n_sum   = '0;
                            n_state = S_SQR;
                        end else begin
                            n_ch = r_ch + 1'b1;
                        end
                    end
                endcase
            end
            S_SQR: begin
                if (r_ph == 2'd0) begin
                    mul_a = qv;
                    mul_b = qv;
                    n_ph  = 2'd1;
                end else begin
                    n_sum = r_sum + 63'(r_prod[63:2]);
                    n_ph  = 2'd0;
                    if (r_k == 2'd3) begin
                        n_rem   = {1'b0, n_sum};
                        n_root  = '0;
                        n_bit   = 64'h4000_0000_0000_0000;
                        n_state = S_SQRT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_SQRT: begin
                if (r_rem >= sq_trial) begin
                    n_rem  = r_rem - sq_trial;
                    n_root = (r_root >> 1) + r_bit;
                end else begin
                    n_root = r_root >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit == 64'd1) begin
                    n_k  = '0;
                    n_ph = '0;
                    n_status = STAT_OK;
                    // zero norm: quaternion passes through
                    n_state  = (n_root == 64'd0) ? S_FIN : S_NDIV;
                end
            end
            S_NDIV: begin
                if (r_ph == 2'd0) begin
                    div_req.start    = 1'b1;
                    div_req.init_rem = DIV_REM_W'(dvd[60:34]);
                    div_req.low      = dvd[33:0];
                    div_req.divisor  = TIME_W'(r_root[31:0]);
                    div_req.steps    = DIV_STEP_W'(DIV_LOW_W);
                    n_ph             = 2'd1;
                end else if (div_rsp.done) begin
                    n_res[6 + r_k] = qnorm;
                    n_ph           = 2'd0;
                    if (r_k == 2'd3) begin
                        n_state = S_FIN;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (!r_ovalid || !i_stall) begin
                    n_out.status     = r_status;
                    n_out.out_time   = r_q;
                    n_out.out_acc_x  = r_res[0];
                    n_out.out_acc_y  = r_res[1];
                    n_out.out_acc_z  = r_res[2];
                    n_out.out_gyro_x = r_res[3];
                    n_out.out_gyro_y = r_res[4];
                    n_out.out_gyro_z = r_res[5];
                    n_out.out_quat_x = r_res[6];
                    n_out.out_quat_y = r_res[7];
                    n_out.out_quat_z = r_res[8];
                    n_out.out_quat_w = r_res[9];
                    n_ovalid         = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `STA_ASSERT(a_count_bound, r_count <= CNT_W'(FIFO_DEPTH))
    `STA_ASSERT(a_eval_two, (r_state != S_EVAL) || (r_count >= CNT_W'(2)))
    `STA_ASSERT_NEXT(a_sync_busy, accept && (i_data.action == ACT_SYNC), o_stall)
    `STA_ASSERT_NEXT(a_push_no_result, accept && (i_data.action == ACT_PUSH) && !r_ovalid,
        !o_valid)

endmodule
